### rtl/xks_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// xks_pkg
// Shared widths, register indexes, seed defaults and the generator step
// for the xorshift keystream scrambler.
// ============================================================================
package xks_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned POS_W       = 2;
   localparam int unsigned CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_X = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_Y = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_Z = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_W = 8'd3;

   localparam logic [WORD_W-1:0] SEED_X_RESET = 32'h4400_00A4;
   localparam logic [WORD_W-1:0] SEED_Y_RESET = 32'h0012_7C00;
   localparam logic [WORD_W-1:0] SEED_Z_RESET = 32'h0400_FFA4;
   localparam logic [WORD_W-1:0] SEED_W_RESET = 32'h1023_5011;

   localparam int unsigned SHIFT_A = 11;
   localparam int unsigned SHIFT_B = 19;
   localparam int unsigned SHIFT_C = 8;

   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [POS_W-1:0]       pos_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      word_type w;
   } gen_state_type;

   typedef struct packed {
      logic fire;
      logic chunk_start;
   } keygen_ctrl_type;

   localparam gen_state_type SEED_RESET =
      '{x: SEED_X_RESET, y: SEED_Y_RESET, z: SEED_Z_RESET, w: SEED_W_RESET};

   function automatic gen_state_type xorshift_step(input gen_state_type s);
      word_type      t;
      gen_state_type r;
      t   = s.x ^ (s.x << SHIFT_A);
      r.x = s.y;
      r.y = s.z;
      r.z = s.w;
      r.w = (s.w ^ (s.w >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
      return r;
   endfunction

endpackage

### rtl/xks_if.sv
`timescale 1ns / 1ps
// ============================================================================
// xks_if
// Valid/ready channel interfaces: data beats in, scrambled beats out and
// seed register writes.
// ============================================================================
interface xks_req_if;
   import xks_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     chunk_start;

   modport source (output valid, output data_byte, output chunk_start, input ready);
   modport sink   (input valid, input data_byte, input chunk_start, output ready);
endinterface

interface xks_rsp_if;
   import xks_pkg::*;
   logic     valid;
   logic     ready;
   byte_type scrambled_byte;
   byte_type key_byte;

   modport source (output valid, output scrambled_byte, output key_byte, input ready);
   modport sink   (input valid, input scrambled_byte, input key_byte, output ready);
endinterface

interface xks_csr_if;
   import xks_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   word_type      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/xks_seed_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// xks_seed_regs
// Seed register file, loaded into the generator at each chunk start.
// ============================================================================
module xks_seed_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  xks_pkg::csr_index_type wr_index,
   input  xks_pkg::word_type      wr_data,
   output xks_pkg::gen_state_type seeds
);
   import xks_pkg::*;

   gen_state_type seeds_ff;
   gen_state_type seeds_in;

   always_comb begin
      seeds_in = seeds_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SEED_X: seeds_in.x = wr_data;
            CSR_SEED_Y: seeds_in.y = wr_data;
            CSR_SEED_Z: seeds_in.z = wr_data;
            CSR_SEED_W: seeds_in.w = wr_data;
            default:    seeds_in   = seeds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeds_ff <= SEED_RESET;
      end else begin
         seeds_ff <= seeds_in;
      end
   end

   assign seeds = seeds_ff;

endmodule

### rtl/xks_keygen.sv
`timescale 1ns / 1ps
// ============================================================================
// xks_keygen
// Xorshift128 generator state, current key word and byte position; yields
// the key byte for the beat in the input register.
// ============================================================================
module xks_keygen (
   input  logic                     clock,
   input  logic                     reset,
   input  xks_pkg::keygen_ctrl_type ctrl,
   input  xks_pkg::gen_state_type   seeds,
   output xks_pkg::byte_type        key_byte
);
   import xks_pkg::*;

   gen_state_type gen_ff;
   gen_state_type gen_in;
   word_type      key_word_ff;
   word_type      key_word_in;
   pos_type       pos_ff;
   pos_type       pos_in;

   gen_state_type gen_cur;
   gen_state_type gen_next;
   pos_type       pos_cur;

   always_comb begin
      gen_cur  = ctrl.chunk_start ? seeds : gen_ff;
      pos_cur  = ctrl.chunk_start ? '0 : pos_ff;
      gen_next = xorshift_step(gen_cur);
      if (pos_cur == '0) begin
         gen_in      = gen_next;
         key_word_in = gen_next.w;
      end else begin
         gen_in      = gen_cur;
         key_word_in = key_word_ff;
      end
      pos_in   = pos_cur + 1'b1;
      key_byte = BYTE_W'(key_word_in >> {pos_cur, 3'b000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= SEED_RESET;
         key_word_ff <= '0;
         pos_ff      <= '0;
      end else if (ctrl.fire) begin
         gen_ff      <= gen_in;
         key_word_ff <= key_word_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

### rtl/xorshift_keystream_scrambler_top.sv
`timescale 1ns / 1ps
// ============================================================================
// xorshift_keystream_scrambler_top
// Byte scrambler: XORs each data beat with a byte of an xorshift128
// keystream, drawing a fresh key word every fourth byte of a chunk.
// ============================================================================
//  channel  dir  handshake        payload
//  req_if   in   valid / ready    data_byte[7:0], chunk_start
//  rsp_if   out  valid / ready    scrambled_byte[7:0], key_byte[7:0]
//  csr_if   in   valid / ready    index[7:0], wdata[31:0] (seed_x..seed_w)
//
//  A req beat passes the input register, then one generator step into the
//  result register. One beat per cycle sustained while rsp_if is ready.
//  Synchronous reset restores the default seeds; no clearing pass.
//  A stalled rsp_if holds the result register; req_if keeps taking a beat
//  while the input register is empty or moving on. csr_if is always ready.
// ============================================================================
module xorshift_keystream_scrambler_top (
   input logic clock,
   input logic reset,
   xks_req_if.sink   req_if,
   xks_rsp_if.source rsp_if,
   xks_csr_if.sink   csr_if
);
   import xks_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   byte_type        in_data_ff;
   logic            in_start_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   byte_type        rsp_scrambled_ff;
   byte_type        rsp_key_ff;
   logic            advance;
   logic            req_fire;
   byte_type        key_byte;
   gen_state_type   seeds;
   keygen_ctrl_type kg_ctrl;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);
   assign csr_if.ready = 1'b1;

   assign kg_ctrl.fire        = advance;
   assign kg_ctrl.chunk_start = in_start_ff;

   xks_seed_regs u_seed_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.wdata),
      .seeds    (seeds)
   );

   xks_keygen u_keygen (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (kg_ctrl),
      .seeds    (seeds),
      .key_byte (key_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff  <= req_if.data_byte;
         in_start_ff <= req_if.chunk_start;
      end
      if (advance) begin
         rsp_scrambled_ff <= in_data_ff ^ key_byte;
         rsp_key_ff       <= key_byte;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.scrambled_byte = rsp_scrambled_ff;
   assign rsp_if.key_byte       = rsp_key_ff;

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register empty after advance");

   a_ready_low_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (in_valid_ff && rsp_valid_ff && !rsp_if.ready))
      else $error("req_if stalled without a full pipeline");

   a_key_recovers_data: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((rsp_scrambled_ff ^ rsp_key_ff) == $past(in_data_ff)))
      else $error("scrambled beat does not unscramble to its data");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for xorshift_keystream_scrambler_top. A scoreboard
// class keeps its own xorshift128 keystream and seed registers, predicts
// every rsp beat from the req beats taken and checks it field by field.
// Seeds are reloaded between phases, with zero, all-ones, mixed, default
// and random settings. Both sides idle and stall at random.
// ============================================================================
module tb;
   import xks_pkg::*;

   localparam csr_index_type CSR_UNMAPPED_LO = 8'd4;
   localparam csr_index_type CSR_UNMAPPED_HI = 8'hFF;

   typedef enum int {SET_RANDOM, SET_ZERO, SET_ONES, SET_EXTREME_MIX, SET_DEFAULT}
      seed_setting_type;

   typedef struct packed {
      byte_type scrambled;
      byte_type key;
   } keyed_byte_type;

   class keystream_scoreboard;
      gen_state_type  seeds;
      gen_state_type  gen;
      word_type       key_word;
      pos_type        byte_pos;
      keyed_byte_type expected_bytes[$];
      int unsigned    errors;

      function new();
         seeds    = '{x: SEED_X_RESET, y: SEED_Y_RESET, z: SEED_Z_RESET, w: SEED_W_RESET};
         gen      = seeds;
         key_word = '0;
         byte_pos = '0;
         errors   = 0;
      endfunction

      function void write_reg(csr_index_type index, word_type value);
         case (index)
            CSR_SEED_X: seeds.x = value;
            CSR_SEED_Y: seeds.y = value;
            CSR_SEED_Z: seeds.z = value;
            CSR_SEED_W: seeds.w = value;
            default: ;
         endcase
      endfunction

      function void note_beat(byte_type data, logic start);
         word_type       mix;
         gen_state_type  nxt_gen;
         keyed_byte_type nxt;
         if (start) begin
            gen      = seeds;
            byte_pos = '0;
         end
         if (byte_pos == '0) begin
            mix       = gen.x ^ (gen.x << SHIFT_A);
            nxt_gen.x = gen.y;
            nxt_gen.y = gen.z;
            nxt_gen.z = gen.w;
            nxt_gen.w = (gen.w ^ (gen.w >> SHIFT_B)) ^ (mix ^ (mix >> SHIFT_C));
            gen       = nxt_gen;
            key_word  = gen.w;
         end
         nxt.key       = key_word[byte_pos*BYTE_W +: BYTE_W];
         nxt.scrambled = data ^ nxt.key;
         byte_pos      = byte_pos + 1'b1;
         expected_bytes.insert(expected_bytes.size(), nxt);
      endfunction

      function void check_beat(byte_type scrambled, byte_type key);
         keyed_byte_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected rsp beat: scrambled_byte %02h key_byte %02h", scrambled, key);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (scrambled !== want.scrambled) begin
            $error("scrambled_byte: expected %02h, actual %02h", want.scrambled, scrambled);
            errors++;
         end
         if (key !== want.key) begin
            $error("key_byte: expected %02h, actual %02h", want.key, key);
            errors++;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   src_idle_on;
   bit   sink_stall_on;
   int   beats_sent;

   keystream_scoreboard sb;

   xks_req_if req_bus ();
   xks_rsp_if rsp_bus ();
   xks_csr_if csr_bus ();

   xorshift_keystream_scrambler_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int send_gap();
      if (!src_idle_on || $urandom_range(0, 2) != 0) return 0;
      return idle_len();
   endfunction

   // rsp side: ready with random stalls
   initial begin
      int hold;
      hold          = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (sink_stall_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold = idle_len();
         end else begin
            rsp_bus.ready <= 1'b1;
            hold = $urandom_range(0, 6);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_beat(rsp_bus.scrambled_byte, rsp_bus.key_byte);
   end

   task automatic send_beat(byte_type data, logic start);
      int gap;
      gap = send_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= data;
      req_bus.chunk_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_beat(data, start);
      beats_sent++;
   endtask

   task automatic stop_sending();
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_reg(csr_index_type index, word_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(index, value);
   endtask

   task automatic program_seeds(word_type x, word_type y, word_type z, word_type w);
      program_reg(CSR_SEED_X, x);
      program_reg(CSR_SEED_Y, y);
      program_reg(CSR_SEED_Z, z);
      program_reg(CSR_SEED_W, w);
      if ($urandom_range(0, 1) == 0)
         program_reg(csr_index_type'($urandom_range(CSR_UNMAPPED_LO, CSR_UNMAPPED_HI)),
                     word_type'($urandom));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_setting(seed_setting_type kind);
      case (kind)
         SET_ZERO:    program_seeds('0, '0, '0, '0);
         SET_ONES:    program_seeds('1, '1, '1, '1);
         SET_DEFAULT: program_seeds(SEED_X_RESET, SEED_Y_RESET, SEED_Z_RESET, SEED_W_RESET);
         SET_EXTREME_MIX:
            program_seeds({32{1'($urandom_range(0, 1))}}, {32{1'($urandom_range(0, 1))}},
                          {32{1'($urandom_range(0, 1))}}, {32{1'($urandom_range(0, 1))}});
         default:
            program_seeds(word_type'($urandom), word_type'($urandom),
                          word_type'($urandom), word_type'($urandom));
      endcase
   endtask

   initial begin
      int len;
      int pick;
      int target;
      int phase_end;
      sb                  = new();
      beats_sent          = 0;
      src_idle_on         = 1'b0;
      sink_stall_on       = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.chunk_start = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.wdata       = '0;
      reset               = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // stream straight out of reset, no chunk start
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hA5, 1'b0);
      send_beat(8'h5A, 1'b0);
      send_beat(8'h01, 1'b0);
      // chunk starts, one mid-word and two back to back, then wrap
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'h80, 1'b1);
      send_beat(8'h7F, 1'b1);
      send_beat(8'h0F, 1'b0);
      send_beat(8'hF0, 1'b0);
      send_beat(8'h3C, 1'b0);
      send_beat(8'hC3, 1'b0);
      send_beat(8'h55, 1'b0);
      stop_sending();
      drain();

      // seeds changed mid-chunk take effect only at the next start
      program_reg(CSR_UNMAPPED_LO, '1);
      program_reg(CSR_UNMAPPED_HI, '0);
      load_setting(SET_ZERO);
      send_beat(8'hAA, 1'b0);
      send_beat(8'h55, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'h12, 1'b0);
      stop_sending();
      drain();
      load_setting(SET_ONES);
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h69, 1'b0);
      send_beat(8'h96, 1'b0);
      send_beat(8'hC0, 1'b0);
      stop_sending();
      drain();
      load_setting(SET_RANDOM);

      target    = beats_sent + 1350;
      phase_end = beats_sent + $urandom_range(150, 300);
      while (beats_sent < target) begin
         src_idle_on   = $urandom_range(0, 3) != 0;
         sink_stall_on = $urandom_range(0, 3) != 0;
         pick          = $urandom_range(0, 9);
         if (pick < 7) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
            for (int i = 0; i < len; i++) send_beat(byte_type'($urandom), i == 0);
         end else if (pick < 9) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) send_beat(byte_type'($urandom), 1'b0);
         end else begin
            send_beat(byte_type'($urandom), 1'($urandom_range(0, 1)));
         end
         if (beats_sent >= phase_end) begin
            // hold until every beat is back, then maybe reseed
            stop_sending();
            drain();
            if ($urandom_range(0, 3) != 0)
               load_setting(seed_setting_type'($urandom_range(SET_RANDOM, SET_DEFAULT)));
            phase_end = beats_sent + $urandom_range(150, 300);
         end
      end

      stop_sending();
      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
rtl/xks_pkg.sv
rtl/xks_if.sv
rtl/xks_seed_regs.sv
rtl/xks_keygen.sv
rtl/xorshift_keystream_scrambler_top.sv
dv/tb.sv
